// ===== hw/rtl/breakpoint_table_interpolator_defines.svh =====
// Assertion macros for the breakpoint table interpolator.
`ifndef BREAKPOINT_TABLE_INTERPOLATOR_DEFINES_SVH
`define BREAKPOINT_TABLE_INTERPOLATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define BTI_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bti assertion failed");
`define BTI_ASSERT_RST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("bti reset assertion failed");
`else
`define BTI_ASSERT(label, clk, rst_n, prop)
`define BTI_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== hw/rtl/bti_pkg.sv =====
// Shared constants and codes of the breakpoint table interpolator.
package bti_pkg;
	localparam int TABLE_DEPTH_DEFAULT = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W = 4;
	localparam int CFG_W = 5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_POINT_COUNT = 1'b0;
	localparam logic REG_CLAMP_ENABLE = 1'b1;
endpackage

// ===== hw/rtl/bti_cell.sv =====
// One breakpoint cell of the rotating table ring.
module bti_cell
	import bti_pkg::*;
(
	input  logic                     clk,
	input  logic                     rot,
	input  logic                     wen,
	input  logic signed [DATA_W-1:0] wx,
	input  logic signed [DATA_W-1:0] wy,
	input  logic signed [DATA_W-1:0] nx,
	input  logic signed [DATA_W-1:0] ny,
	output logic signed [DATA_W-1:0] x,
	output logic signed [DATA_W-1:0] y
);
	logic signed [DATA_W-1:0] x_q, y_q;

	// load from the write port, or take the neighbor's entry on rotation
	always_ff @(posedge clk) begin
		if (wen) begin
			x_q <= wx;
			y_q <= wy;
		end else if (rot) begin
			x_q <= nx;
			y_q <= ny;
		end
	end

	assign x = x_q;
	assign y = y_q;
endmodule

// ===== hw/rtl/bti_muldiv.sv =====
// Shift-add multiply then restoring divide: (a * b) / d, unsigned, one bit per cycle.
module bti_muldiv
	import bti_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	input  logic [DATA_W-1:0] d,
	output logic              done,
	output logic [2*DATA_W-1:0] q
);
	localparam int LAST = 3 * DATA_W - 1;
	localparam int CNT_W = $clog2(LAST + 1);

	logic              busy_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [2*DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] a_q, b_q, d_q, rem_q;
	logic [DATA_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, acc_q[2*DATA_W-1]};
	assign fits = trial >= {1'b0, d_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: multiply phase, then divide phase reusing acc as quotient
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			rem_q <= '0;
			a_q <= a;
			b_q <= b;
			d_q <= d;
		end else if (busy_q) begin
			if (cnt_q < CNT_W'(DATA_W)) begin
				acc_q <= {acc_q[2*DATA_W-2:0], 1'b0}
					+ (b_q[DATA_W-1] ? {{DATA_W{1'b0}}, a_q} : '0);
				b_q <= {b_q[DATA_W-2:0], 1'b0};
			end else begin
				rem_q <= fits ? DATA_W'(trial - {1'b0, d_q}) : trial[DATA_W-1:0];
				acc_q <= {acc_q[2*DATA_W-2:0], fits};
			end
		end
	end

	assign done = done_q;
	assign q = acc_q;
endmodule

// ===== hw/rtl/breakpoint_table_interpolator.sv =====
// Top level of the breakpoint table interpolator: cell ring, search control, arithmetic.
//
// channel | signals                                   | transfer when
// in      | in_valid in_stall op entry_index point_x/y | in_valid && !in_stall
// out     | out_valid out_stall result_y in_range      | out_valid && !out_stall
// cfg     | cfg_we cfg_index cfg_data                  | cfg_we
//
// A write item is taken while idle. A query rotates the cell ring twice (end points,
// then segments), then runs the multiply-divide unit when a segment matched.
// With fewer than two points a query answers without rotating the ring.
// Reset clears control and configuration registers; table cells and datapath registers hold no reset value.
// Input stalls for the whole query; a finished answer waits in ST_DONE while the
// output register still holds a stalled result.
`include "breakpoint_table_interpolator_defines.svh"
module breakpoint_table_interpolator
	import bti_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     op,
	input  logic [IDX_W-1:0]         entry_index,
	input  logic signed [DATA_W-1:0] point_x,
	input  logic signed [DATA_W-1:0] point_y,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] result_y,
	output logic                     in_range,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = $clog2(TABLE_DEPTH);
	localparam int RW = DATA_W + 2;

	typedef enum logic [2:0] {ST_IDLE, ST_ENDS, ST_SEGS, ST_CALC, ST_DONE} state_t;

	state_t state_q;
	logic [CFG_W-1:0] point_count_q;
	logic clamp_q;
	logic [CW-1:0] n_q;
	logic [SW-1:0] step_q;
	logic signed [DATA_W-1:0] qx_q, xf_q, yf_q, xl_q, yl_q, y0_q;
	logic [DATA_W-1:0] num_q, den_q, dym_q;
	logic dyneg_q, hit_q, md_start_q;
	logic signed [DATA_W-1:0] res_q;
	logic out_valid_q;
	logic signed [DATA_W-1:0] res_y_q;
	logic res_hit_q;

	logic signed [DATA_W-1:0] cx [TABLE_DEPTH];
	logic signed [DATA_W-1:0] cy [TABLE_DEPTH];
	logic rot, accept, wr, last_step, desc, seg_ok, seg_match;
	logic signed [DATA_W:0] dnum, dden, ddy;
	logic signed [RW-1:0] rsum;
	logic signed [DATA_W-1:0] rsat, clamp_val;
	logic md_done;
	logic [2*DATA_W-1:0] md_q;

	assign accept = in_valid && !in_stall;
	assign wr = accept && (op == OP_WRITE);
	assign rot = (state_q == ST_ENDS) || (state_q == ST_SEGS);
	assign last_step = step_q == SW'(TABLE_DEPTH - 1);

	// ring of cells; cell i takes its entry from cell i+1
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		bti_cell u_cell (
			.clk(clk),
			.rot(rot),
			.wen(wr && (32'(entry_index) == i)),
			.wx(point_x),
			.wy(point_y),
			.nx(cx[(i + 1) % TABLE_DEPTH]),
			.ny(cy[(i + 1) % TABLE_DEPTH]),
			.x(cx[i]),
			.y(cy[i])
		);
	end

	// segment test on cells 0 and 1, which hold entries step and step+1
	assign desc = xf_q > xl_q;
	assign seg_ok = (CW'(step_q) + CW'(1)) < n_q;
	assign seg_match = desc ? (qx_q <= cx[0] && qx_q > cx[1])
	                        : (qx_q > cx[0] && qx_q <= cx[1]);
	assign dnum = {qx_q[DATA_W-1], qx_q} - {cx[0][DATA_W-1], cx[0]};
	assign dden = {cx[1][DATA_W-1], cx[1]} - {cx[0][DATA_W-1], cx[0]};
	assign ddy = {cy[1][DATA_W-1], cy[1]} - {cy[0][DATA_W-1], cy[0]};

	// end value for an unmatched query
	always_comb begin
		clamp_val = '0;
		if (clamp_q) begin
			if (desc ? (qx_q >= xf_q) : (qx_q <= xf_q))
				clamp_val = yf_q;
			else if (desc ? (qx_q <= xl_q) : (qx_q >= xl_q))
				clamp_val = yl_q;
		end
	end

	// y0 plus or minus quotient, saturated
	assign rsum = dyneg_q ? (RW'(y0_q) - RW'(md_q[DATA_W:0]))
	                      : (RW'(y0_q) + RW'(md_q[DATA_W:0]));
	always_comb begin
		if (rsum > RW'(32'sh7fffffff))
			rsat = 32'sh7fffffff;
		else if (rsum < -RW'(33'sh080000000))
			rsat = 32'sh80000000;
		else
			rsat = rsum[DATA_W-1:0];
	end

	bti_muldiv u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(md_start_q),
		.a(dym_q),
		.b(num_q),
		.d(den_q),
		.done(md_done),
		.q(md_q)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			clamp_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POINT_COUNT: point_count_q <= cfg_data;
				REG_CLAMP_ENABLE: clamp_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// search and result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			hit_q <= 1'b0;
			md_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			n_q <= '0;
		end else begin
			md_start_q <= 1'b0;
			// ST_DONE loads the output register itself
			if (out_valid_q && !out_stall && state_q != ST_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && op == OP_QUERY) begin
						qx_q <= point_x;
						step_q <= '0;
						hit_q <= 1'b0;
						res_q <= '0;
						if (32'(point_count_q) > TABLE_DEPTH)
							n_q <= CW'(TABLE_DEPTH);
						else
							n_q <= CW'(point_count_q);
						if (point_count_q < CFG_W'(2))
							state_q <= ST_DONE;
						else
							state_q <= ST_ENDS;
					end
				end
				ST_ENDS: begin
					if (step_q == '0) begin
						xf_q <= cx[0];
						yf_q <= cy[0];
					end
					if ((CW'(step_q) + CW'(1)) == n_q) begin
						xl_q <= cx[0];
						yl_q <= cy[0];
					end
					step_q <= last_step ? '0 : step_q + SW'(1);
					if (last_step)
						state_q <= ST_SEGS;
				end
				ST_SEGS: begin
					if (!hit_q && seg_ok && seg_match) begin
						hit_q <= 1'b1;
						y0_q <= cy[0];
						num_q <= dnum[DATA_W] ? DATA_W'(-dnum) : dnum[DATA_W-1:0];
						den_q <= dden[DATA_W] ? DATA_W'(-dden) : dden[DATA_W-1:0];
						dym_q <= ddy[DATA_W] ? DATA_W'(-ddy) : ddy[DATA_W-1:0];
						dyneg_q <= ddy[DATA_W];
					end
					step_q <= last_step ? '0 : step_q + SW'(1);
					if (last_step) begin
						if (hit_q || (seg_ok && seg_match)) begin
							md_start_q <= 1'b1;
							state_q <= ST_CALC;
						end else begin
							res_q <= clamp_val;
							state_q <= ST_DONE;
						end
					end
				end
				ST_CALC: begin
					if (md_done) begin
						res_q <= rsat;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						res_y_q <= res_q;
						res_hit_q <= hit_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign result_y = res_y_q;
	assign in_range = res_hit_q;

	`BTI_ASSERT(a_done_in_calc, clk, arst_n, md_done |-> state_q == ST_CALC)
	`BTI_ASSERT(a_segs_follow_ends, clk, arst_n, (state_q == ST_SEGS && step_q == '0) |-> $past(rot))
	`BTI_ASSERT(a_ring_home, clk, arst_n, state_q == ST_IDLE |-> step_q == '0)
endmodule
